@@ rtl/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// spc_pkg
// shared types and constants for the stream pattern censor
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int BYTE_W      = 8;
    localparam int PATTERN_W   = 64;
    localparam int LENGTH_W    = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [BYTE_W-1:0] MASK_BYTE    = 8'h2A;
    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } in_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              stream_done;
    } out_beat_t;

    // window cell control
    typedef struct packed {
        logic enable;
        logic hit;
        logic shift;
    } win_ctrl_t;

    // output cell control
    typedef struct packed {
        logic load;
        logic shift;
    } out_ctrl_t;

endpackage

@@ rtl/spc_win_cell.sv @@
// ----------------------------------------------------------------------------
// spc_win_cell
// one byte of the pending window with its pattern compare
// ----------------------------------------------------------------------------
module spc_win_cell (
    input  logic                          clk,
    input  spc_pkg::win_ctrl_t            ctrl,
    input  logic [spc_pkg::BYTE_W-1:0]    in_byte,
    input  logic [spc_pkg::BYTE_W-1:0]    next_byte,
    input  logic [spc_pkg::BYTE_W-1:0]    pat_byte,
    output logic [spc_pkg::BYTE_W-1:0]    win_byte,
    output logic                          eq
);

    logic [spc_pkg::BYTE_W-1:0] byte_reg;
    logic [spc_pkg::BYTE_W-1:0] byte_next;

    // window content including the byte arriving this cycle
    assign win_byte = ctrl.hit ? in_byte : byte_reg;
    assign eq       = (win_byte == pat_byte);

    // shift takes the neighbor's updated byte
    assign byte_next = ctrl.shift ? next_byte : win_byte;

    always_ff @(posedge clk)
    begin
        if (ctrl.enable)
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

@@ rtl/spc_out_cell.sv @@
// ----------------------------------------------------------------------------
// spc_out_cell
// one slot of the result chain, shifts toward the output port
// ----------------------------------------------------------------------------
module spc_out_cell (
    input  logic                  clk,
    input  spc_pkg::out_ctrl_t    ctrl,
    input  spc_pkg::out_beat_t    load_beat,
    input  spc_pkg::out_beat_t    next_beat,
    output spc_pkg::out_beat_t    beat
);

    spc_pkg::out_beat_t beat_reg;

    assign beat = beat_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            beat_reg <= load_beat;
        end
        else if (ctrl.shift)
        begin
            beat_reg <= next_beat;
        end
    end

endmodule

@@ rtl/stream_pattern_censor.sv @@
// ----------------------------------------------------------------------------
// stream_pattern_censor
// byte stream filter that masks every occurrence of a pattern with '*'
// ----------------------------------------------------------------------------
// usage
//   in channel: one text byte per beat plus an end-of-stream flag
//   out channel: one byte per beat, run_last on the last beat caused by an
//     input beat, stream_done on that beat when the input ended the stream
//   cfg channel: index 0 writes the 64-bit pattern (first byte in bits 7:0),
//     index 1 writes the length; a length write drops pending bytes; write
//     only while the block is idle
// latency: results of an input beat appear from the next cycle on
// throughput: one input beat per cycle while each beat gives at most one
//   result; a beat that releases k bytes (match or flush) takes k output
//   cycles, set by the single output port draining the result chain
// the window is a row of MAX_PATTERN_BYTES cells compared in parallel; the
// results go into a chain of 2*MAX_PATTERN_BYTES cells shifting toward out
// reset: window and result chain empty, pattern and length zero (pass-through)
// stall: a stalled receiver holds the head beat; input is taken while the
//   chain holds no more than MAX_PATTERN_BYTES beats
// ----------------------------------------------------------------------------
module stream_pattern_censor #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  spc_pkg::in_beat_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output spc_pkg::out_beat_t                   out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [spc_pkg::PATTERN_W-1:0]        cfg_data
);

    localparam int MAXB  = MAX_PATTERN_BYTES;
    localparam int CW    = $clog2(MAXB + 1);          // window count width
    localparam int DEPTH = 2 * MAXB;                  // result chain depth
    localparam int OCW   = $clog2(DEPTH + 1);         // chain occupancy width
    localparam int IW    = (MAXB > 1) ? $clog2(MAXB) : 1;

    // configuration registers
    logic [spc_pkg::PATTERN_W-1:0] pattern_reg;
    logic [spc_pkg::LENGTH_W-1:0]  plen_reg;

    // window fill and result chain occupancy
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [OCW-1:0] occ_reg;
    logic [OCW-1:0] occ_next;

    logic           accept;
    logic           take;
    logic           cfg_len_wr;

    logic [CW-1:0]  len;
    logic [CW-1:0]  pos;          // slot of the arriving byte
    logic [CW-1:0]  fill;         // fill after the arriving byte
    logic           full;
    logic           match;
    logic           match_full;
    logic           flush;
    logic           win_shift;
    logic [CW-1:0]  n_res;        // results caused by this beat

    logic [spc_pkg::BYTE_W-1:0] win_byte [MAXB];
    logic [MAXB-1:0]            eq;
    logic [MAXB-1:0]            active;

    spc_pkg::out_beat_t burst [MAXB];
    spc_pkg::out_beat_t chain [DEPTH];

    logic [OCW-1:0] base;

    assign accept     = in_valid && in_ready;
    assign take       = out_valid && out_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_len_wr = cfg_valid && (cfg_index == spc_pkg::REG_PATTERN_LENGTH);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spc_pkg::REG_PATTERN_BYTES:  pattern_reg <= cfg_data;
                spc_pkg::REG_PATTERN_LENGTH: plen_reg <= cfg_data[spc_pkg::LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // lengths above the window size act as the window size
    assign len = (plen_reg > spc_pkg::LENGTH_W'(MAXB)) ? CW'(MAXB) : plen_reg[CW-1:0];

    // ------------------------------------------------------------------
    // window step decisions
    // ------------------------------------------------------------------
    assign pos   = (count_reg >= len) ? '0 : count_reg;
    assign fill  = pos + CW'(1);
    assign full  = (len != '0) && (fill == len);
    assign match = &(eq | ~active);
    assign match_full = full && match;
    assign flush = (in_data.data_byte == spc_pkg::NEWLINE_BYTE) || in_data.end_of_stream;
    // no match on a full window and no flush: oldest byte leaves, rest moves down
    assign win_shift  = full && !match && !flush;

    always_comb
    begin
        if (len == '0)
        begin
            n_res      = CW'(1);
            count_next = '0;
        end
        else if (match_full)
        begin
            n_res      = len;
            count_next = '0;
        end
        else if (full)
        begin
            n_res      = flush ? len : CW'(1);
            count_next = flush ? '0 : len - CW'(1);
        end
        else
        begin
            n_res      = flush ? fill : '0;
            count_next = flush ? '0 : fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_len_wr)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // window cells
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAXB; i++)
    begin : g_win
        spc_pkg::win_ctrl_t         wctrl;
        logic [spc_pkg::BYTE_W-1:0] nb;

        assign wctrl.enable = accept;
        assign wctrl.hit    = (pos == CW'(i));
        assign wctrl.shift  = win_shift;
        assign active[i]    = (CW'(i) < len);

        if (i < MAXB - 1)
        begin : g_mid
            assign nb = win_byte[i+1];
        end
        else
        begin : g_end
            assign nb = win_byte[i];
        end

        spc_win_cell u_cell (
            .clk       (clk),
            .ctrl      (wctrl),
            .in_byte   (in_data.data_byte),
            .next_byte (nb),
            .pat_byte  (pattern_reg[spc_pkg::BYTE_W*i +: spc_pkg::BYTE_W]),
            .win_byte  (win_byte[i]),
            .eq        (eq[i])
        );

        // result beat k of this input
        assign burst[i].out_byte    = match_full ? spc_pkg::MASK_BYTE : win_byte[i];
        assign burst[i].run_last    = (CW'(i) == n_res - CW'(1));
        assign burst[i].stream_done = (CW'(i) == n_res - CW'(1)) && in_data.end_of_stream;
    end

    // ------------------------------------------------------------------
    // result chain: new results go in right behind the ones still waiting
    // ------------------------------------------------------------------
    assign base = occ_reg - OCW'(take);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_out
        spc_pkg::out_ctrl_t octrl;
        spc_pkg::out_beat_t nxt;
        logic [OCW-1:0]     off;

        assign off         = OCW'(i) - base;
        assign octrl.load  = accept && (OCW'(i) >= base) && (OCW'(i) < base + OCW'(n_res));
        assign octrl.shift = take;

        if (i < DEPTH - 1)
        begin : g_mid
            assign nxt = chain[i+1];
        end
        else
        begin : g_end
            assign nxt = chain[i];
        end

        spc_out_cell u_cell (
            .clk       (clk),
            .ctrl      (octrl),
            .load_beat (burst[off[IW-1:0]]),
            .next_beat (nxt),
            .beat      (chain[i])
        );
    end

    assign occ_next = occ_reg - OCW'(take) + (accept ? OCW'(n_res) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign out_valid = (occ_reg != '0);
    assign out_data  = chain[0];
    assign in_ready  = (occ_reg <= OCW'(MAXB));

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCW'(DEPTH))
        else $error("result chain overflow");

    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_valid) |=> (count_reg < len) || (len == '0))
        else $error("window fill reached pattern length");

    a_lone_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == OCW'(1)) |-> out_data.run_last)
        else $error("single waiting beat does not end its run");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.stream_done) |-> out_data.run_last)
        else $error("stream_done off the last beat of a run");

    a_len_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_len_wr |=> (count_reg == '0))
        else $error("length write left pending bytes");

endmodule
